// File: sv/met_pkg.sv
// Shared constants for the mandelbrot escape-time pixel block.
// State codes, register indexes and fixed field widths; no dependencies.
package met_pkg;

  localparam int WORD_W  = 32;
  localparam int COORD_W = 12;
  localparam int THR_W   = 31;
  localparam int GRAY_W  = 8;
  localparam int ITER_W  = 7;
  localparam int CIDX_W  = 3;
  localparam int STATE_W = 4;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CIDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ESC_THR     = 3'd4;

  // register reset values
  localparam word_t             RST_REAL_ORIGIN = -32'sd536870912;
  localparam word_t             RST_IMAG_ORIGIN = -32'sd268435456;
  localparam word_t             RST_REAL_STEP   = 32'sd786432;
  localparam word_t             RST_IMAG_STEP   = 32'sd699051;
  localparam logic [THR_W-1:0]  RST_ESC_THR     = 31'd1073741824;

  // sequencer states
  localparam state_t S_IDLE = 4'd0;
  localparam state_t S_MR   = 4'd1;
  localparam state_t S_MI   = 4'd2;
  localparam state_t S_CI   = 4'd3;
  localparam state_t S_II   = 4'd4;
  localparam state_t S_RI   = 4'd5;
  localparam state_t S_UPD  = 4'd6;
  localparam state_t S_GRAY = 4'd7;
  localparam state_t S_DIV  = 4'd8;
  localparam state_t S_OUT  = 4'd9;

endpackage

// File: sv/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time evaluator for one pixel per transaction.
// Uses met_pkg for state codes, register indexes and field widths.
// A pixel (column, row) maps to c = origin + index * step; z = z*z + c is iterated from zero
// in signed fixed point with FRAC_BITS fraction bits until MAX_ITERATIONS is reached or
// |z|^2 exceeds the escape threshold. All products go through one registered 32x32 signed
// multiplier: states S_MR, S_MI and S_CI map the coordinate, then each iteration passes
// through S_II, S_RI and S_UPD (z_re^2, z_im^2 with the escape test, z_re*z_im). A pixel
// that escapes runs S_II and S_RI once more for the failing escape test, then S_GRAY feeds
// count * 510 + limit times the reciprocal of twice the limit into the multiplier, S_DIV
// takes the rounded gray level from the product and S_OUT loads the output register.
// A pixel that reaches the limit skips the escape test and the multiply and goes from
// S_GRAY straight to S_OUT. The sequencer returns to idle before the next pixel is accepted;
// the multiplier is the bottleneck. in_stall stays high while a pixel is in progress, and a
// finished result may wait in the output register while the next pixel is accepted.
module mandelbrot_escape_time_pixel
  import met_pkg::*;
#(
  parameter int MAX_ITERATIONS = 100,
  parameter int FRAC_BITS      = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  in_column,
  input  logic [COORD_W-1:0]  in_row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [GRAY_W-1:0]   out_gray,
  output logic [ITER_W-1:0]   out_iterations,
  output logic                out_inside_res
);

  localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
  localparam int SQ_W  = 2 * WORD_W - FRAC_BITS;
  localparam int NUM_W = $clog2(MAX_ITERATIONS * 511 + 1);
  // reciprocal of twice the limit, exact floor division for any NUM_W-bit numerator
  localparam int     GSH      = NUM_W + $clog2(2 * MAX_ITERATIONS);
  localparam longint RCP_L    = ((longint'(1) << GSH) + 2 * MAX_ITERATIONS - 1) /
                                (2 * MAX_ITERATIONS);
  localparam word_t  GRAY_RCP = WORD_W'(RCP_L);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ITERATIONS);
  localparam logic [NUM_W-1:0] NUM_OFS  = NUM_W'(MAX_ITERATIONS);

  // configuration registers
  word_t             real_origin_r, imag_origin_r, real_step_r, imag_step_r;
  logic [THR_W-1:0]  esc_thr_r;

  // datapath and control registers
  state_t                   state_r, state_nxt;
  logic [COORD_W-1:0]       col_r, col_nxt, row_r, row_nxt;
  word_t                    cr_r, cr_nxt, ci_r, ci_nxt;
  word_t                    zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [2*WORD_W-1:0] prod_r;
  logic signed [SQ_W-1:0]   rr_r, rr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [GRAY_W-1:0]        gray_r, gray_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [GRAY_W-1:0]        out_gray_r, out_gray_nxt;
  logic [ITER_W-1:0]        out_iter_r, out_iter_nxt;
  logic                     out_inside_r, out_inside_nxt;

  // shared multiplier operands
  word_t mul_a, mul_b;

  logic signed [2*WORD_W-1:0] sq_full, ri_full;
  logic signed [SQ_W-1:0]     ii_cur;
  logic signed [SQ_W:0]       esc_sum, thr_ext;
  logic                       escape;
  logic [NUM_W-1:0]           cnt_w, num;
  logic [CNT_W+ITER_W-1:0]    cnt_ext;

  always_comb begin
    case (state_r)
      S_MR: begin
        mul_a = $signed(WORD_W'(col_r));
        mul_b = real_step_r;
      end
      S_MI: begin
        mul_a = $signed(WORD_W'(row_r));
        mul_b = imag_step_r;
      end
      S_II: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      S_RI: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      S_GRAY: begin
        mul_a = $signed(WORD_W'(num));
        mul_b = GRAY_RCP;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
    endcase
  end

  assign sq_full = prod_r >>> FRAC_BITS;
  assign ri_full = prod_r >>> (FRAC_BITS - 1);
  assign ii_cur  = sq_full[SQ_W-1:0];
  assign esc_sum = (SQ_W+1)'(rr_r) + (SQ_W+1)'(ii_cur);
  assign thr_ext = $signed({{(SQ_W+1-THR_W){1'b0}}, esc_thr_r});
  assign escape  = esc_sum > thr_ext;

  // count * 510 + limit, numerator of the rounded gray level
  assign cnt_w   = NUM_W'(count_r);
  assign num     = (cnt_w << 9) - (cnt_w << 1) + NUM_OFS;
  assign cnt_ext = {{ITER_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    cr_nxt         = cr_r;
    ci_nxt         = ci_r;
    zr_nxt         = zr_r;
    zi_nxt         = zi_r;
    rr_nxt         = rr_r;
    count_nxt      = count_r;
    gray_nxt       = gray_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_gray_nxt   = out_gray_r;
    out_iter_nxt   = out_iter_r;
    out_inside_nxt = out_inside_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_nxt   = in_column;
          row_nxt   = in_row;
          zr_nxt    = '0;
          zi_nxt    = '0;
          count_nxt = '0;
          state_nxt = S_MR;
        end
      end
      S_MR: state_nxt = S_MI;
      S_MI: begin
        cr_nxt    = real_origin_r + prod_r[WORD_W-1:0];
        state_nxt = S_CI;
      end
      S_CI: begin
        ci_nxt    = imag_origin_r + prod_r[WORD_W-1:0];
        state_nxt = S_II;
      end
      S_II: begin
        rr_nxt    = sq_full[SQ_W-1:0];
        state_nxt = S_RI;
      end
      S_RI: begin
        if (escape) begin
          state_nxt = S_GRAY;
        end else begin
          zr_nxt    = rr_r[WORD_W-1:0] - ii_cur[WORD_W-1:0] + cr_r;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // multiplier already squares the new real part here
        zi_nxt    = ri_full[WORD_W-1:0] + ci_r;
        count_nxt = count_r + 1'b1;
        state_nxt = (count_nxt == CNT_MAX) ? S_GRAY : S_II;
      end
      S_GRAY: begin
        if (count_r == CNT_MAX) begin
          gray_nxt  = '1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // scaled product holds the quotient above GSH
        gray_nxt  = prod_r[GSH +: GRAY_W];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_gray_nxt   = gray_r;
          out_iter_nxt   = cnt_ext[ITER_W-1:0];
          out_inside_nxt = (count_r == CNT_MAX);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      real_origin_r <= RST_REAL_ORIGIN;
      imag_origin_r <= RST_IMAG_ORIGIN;
      real_step_r   <= RST_REAL_STEP;
      imag_step_r   <= RST_IMAG_STEP;
      esc_thr_r     <= RST_ESC_THR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_REAL_ORIGIN: real_origin_r <= $signed(cfg_wdata);
          REG_IMAG_ORIGIN: imag_origin_r <= $signed(cfg_wdata);
          REG_REAL_STEP:   real_step_r   <= $signed(cfg_wdata);
          REG_IMAG_STEP:   imag_step_r   <= $signed(cfg_wdata);
          REG_ESC_THR:     esc_thr_r     <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= mul_a * mul_b;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    cr_r         <= cr_nxt;
    ci_r         <= ci_nxt;
    zr_r         <= zr_nxt;
    zi_r         <= zi_nxt;
    rr_r         <= rr_nxt;
    count_r      <= count_nxt;
    gray_r       <= gray_nxt;
    out_gray_r   <= out_gray_nxt;
    out_iter_r   <= out_iter_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_gray       = out_gray_r;
  assign out_iterations = out_iter_r;
  assign out_inside_res = out_inside_r;

  // a new result only comes from the output load state
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared outside output load");

  // iteration count never passes the limit while iterating
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_II || state_r == S_RI || state_r == S_UPD) |-> count_r < CNT_MAX)
    else $error("iteration count past limit");

  // inside pixels always read as full white
  a_inside_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> out_gray_r == '1)
    else $error("inside pixel without full gray");

endmodule

// File: bench/escape_tb_pkg.sv
// Scoreboard for the mandelbrot escape-time pixel bench: a mirror of the view
// registers, a per-pixel escape-time predictor and the queue of pending results.
// Depends on met_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps
package escape_tb_pkg;
  import met_pkg::*;

  localparam int ITER_LIMIT = 100;
  localparam int FRAC_W     = 28;

  typedef struct {
    logic [GRAY_W-1:0] gray;
    logic [ITER_W-1:0] iterations;
    logic              inside_res;
  } pixel_res_t;

  class escape_scoreboard;
    word_t            real_origin;
    word_t            imag_origin;
    word_t            real_step;
    word_t            imag_step;
    logic [THR_W-1:0] esc_thr;
    pixel_res_t       pending_pixels[$];
    int               errors;

    function new();
      real_origin = RST_REAL_ORIGIN;
      imag_origin = RST_IMAG_ORIGIN;
      real_step   = RST_REAL_STEP;
      imag_step   = RST_IMAG_STEP;
      esc_thr     = RST_ESC_THR;
      errors      = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_REAL_ORIGIN: real_origin = data;
        REG_IMAG_ORIGIN: imag_origin = data;
        REG_REAL_STEP:   real_step = data;
        REG_IMAG_STEP:   imag_step = data;
        REG_ESC_THR:     esc_thr = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function pixel_res_t escape_time(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      longint     cr, ci, zr, zi, rr, ii, ri;
      int         count;
      pixel_res_t res;
      // coordinates are exact, then wrapped to a 32-bit word
      cr = int'(longint'(real_origin) + longint'(col) * longint'(real_step));
      ci = int'(longint'(imag_origin) + longint'(row) * longint'(imag_step));
      zr = 0;
      zi = 0;
      count = 0;
      while (count < ITER_LIMIT) begin
        rr = (zr * zr) >>> FRAC_W;
        ii = (zi * zi) >>> FRAC_W;
        if (rr + ii > longint'(esc_thr)) break;
        ri = (zr * zi) >>> (FRAC_W - 1);
        zr = int'(rr - ii + cr);
        zi = int'(ri + ci);
        count++;
      end
      res.inside_res = (count == ITER_LIMIT);
      res.gray       = res.inside_res ? 8'd255 :
                       GRAY_W'((count * 510 + ITER_LIMIT) / (2 * ITER_LIMIT));
      res.iterations = count[ITER_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      pending_pixels.push_back(escape_time(col, row));
    endfunction

    function void check_pixel(logic [GRAY_W-1:0] gray, logic [ITER_W-1:0] iterations,
                              logic inside_res);
      pixel_res_t exp_res;
      if (pending_pixels.size() == 0) begin
        $error("result transaction with no pixel pending");
        errors++;
        return;
      end
      exp_res = pending_pixels.pop_front();
      if (gray !== exp_res.gray) begin
        $error("gray: expected %0d, got %0d", exp_res.gray, gray);
        errors++;
      end
      if (iterations !== exp_res.iterations) begin
        $error("iterations: expected %0d, got %0d", exp_res.iterations, iterations);
        errors++;
      end
      if (inside_res !== exp_res.inside_res) begin
        $error("inside_res: expected %0d, got %0d", exp_res.inside_res, inside_res);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
// Top-level bench for mandelbrot_escape_time_pixel: directed views and pixels,
// then random views with random pixels under random idling on both channels.
// Depends on met_pkg and escape_tb_pkg (scoreboard and predictor).
`timescale 1ns / 1ps
module tb_top;
  import met_pkg::*;
  import escape_tb_pkg::*;

  localparam logic [WORD_W-1:0] THR_FOUR  = 32'd1073741824;
  localparam logic [WORD_W-1:0] THR_TWO   = 32'd536870912;
  localparam logic [WORD_W-1:0] THR_MAX   = 32'h7FFF_FFFF;
  localparam word_t             WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t             WORD_MIN  = 32'sh8000_0000;
  localparam int                RAND_PHASES = 14;
  localparam int                PHASE_PIXELS = 125;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic [COORD_W-1:0]   in_column = '0;
  logic [COORD_W-1:0]   in_row = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [GRAY_W-1:0]    out_gray;
  logic [ITER_W-1:0]    out_iterations;
  logic                 out_inside_res;
  bit                   quiet = 1'b0;

  escape_scoreboard sb = new();

  mandelbrot_escape_time_pixel #(
    .MAX_ITERATIONS(ITER_LIMIT),
    .FRAC_BITS(FRAC_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_column(in_column),
    .in_row(in_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_gray(out_gray),
    .out_iterations(out_iterations),
    .out_inside_res(out_inside_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_column, in_row);
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_gray, out_iterations, out_inside_res);
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic load_view(word_t ro, word_t io, word_t rs, word_t is_v,
                           logic [WORD_W-1:0] thr);
    logic [CIDX_W-1:0] regs [5] = '{REG_REAL_ORIGIN, REG_IMAG_ORIGIN, REG_REAL_STEP,
                                    REG_IMAG_STEP, REG_ESC_THR};
    logic [WORD_W-1:0] vals [5];
    vals = '{ro, io, rs, is_v, thr};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_view();
    word_t             ro, io, rs, is_v;
    logic [WORD_W-1:0] thr;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        // view around the set, origins roughly -2.5..0.5 by -1.5..1.5
        ro   = -32'sd671088640 + word_t'($urandom_range(0, 805306368));
        io   = -32'sd402653184 + word_t'($urandom_range(0, 805306368));
        rs   = word_t'($urandom_range(0, 400000));
        is_v = word_t'($urandom_range(0, 400000));
        if ($urandom_range(0, 3) == 0) rs = -rs;
        if ($urandom_range(0, 3) == 0) is_v = -is_v;
      end
      3: begin
        ro   = word_t'($urandom());
        io   = word_t'($urandom());
        rs   = word_t'($urandom());
        is_v = word_t'($urandom());
      end
      4: begin
        // zoom near the boundary, where counts spread widely
        ro   = -32'sd201326592 + word_t'($urandom_range(0, 16777216));
        io   = 32'sd26843545 + word_t'($urandom_range(0, 16777216));
        rs   = word_t'($urandom_range(0, 3000));
        is_v = word_t'($urandom_range(0, 3000));
      end
      default: begin
        // coordinates that wrap around the word
        ro   = WORD_MAX - word_t'($urandom_range(0, 65535));
        io   = WORD_MIN + word_t'($urandom_range(0, 65535));
        rs   = WORD_MAX - word_t'($urandom_range(0, 1 << 20));
        is_v = WORD_MIN + word_t'($urandom_range(0, 1 << 20));
      end
    endcase
    case ($urandom_range(0, 4))
      0: thr = THR_FOUR;
      1: thr = THR_TWO;
      2: thr = $urandom();
      3: thr = {1'($urandom_range(0, 1)), THR_MAX[THR_W-1:0]};
      default: thr = $urandom_range(0, 1 << 26);
    endcase
    load_view(ro, io, rs, is_v, thr);
  endtask

  initial begin
    logic [COORD_W-1:0] col, row;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: corners, points inside the set and near its edge
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd683, 12'd384);
    send_pixel(12'd512, 12'd384);
    send_pixel(12'd1023, 12'd767);
    drain();

    // c = 0 with zero threshold stays at the limit
    load_view(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // c = 1 with zero threshold escapes after one step
    load_view(32'sd268435456, 32'sd0, 32'sd0, 32'sd0, 32'd0);
    send_pixel(12'd7, 12'd9);
    drain();

    // extreme registers: coordinate and iterate wrap
    load_view(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd2);
    drain();

    load_view(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, THR_TWO);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // default framing with a threshold of two in place of the reset value of four
    load_view(RST_REAL_ORIGIN, RST_IMAG_ORIGIN, RST_REAL_STEP, RST_IMAG_STEP, THR_TWO);
    send_pixel(12'd512, 12'd384);
    send_pixel(12'd300, 12'd300);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'd760, 12'd500);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      random_view();
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end else begin
          col = $urandom_range(0, 4095);
          row = $urandom_range(0, 4095);
        end
        send_pixel(col, row);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $error("%0d expected pixel results never arrived", sb.pending_count());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
